FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the encoder modules. They expect clk
// and rst_n in scope and are off while reset is held.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

`define ASSERT_NEVER(label, expr) `ASSERT_CLK(label, !(expr))

`endif

FILE: sv/sote_pkg.sv
// ----------------------------------------------------------------------------
// Store operand text encoder package
// Types, codes, character constants and the register name lookup.
// ----------------------------------------------------------------------------
package sote_pkg;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_DATA_NAME  = 4'd1,
    PH_SPACE      = 4'd2,
    PH_OFF_START  = 4'd3,
    PH_OFF_SIGNED = 4'd4,
    PH_OFF_DIGITS = 4'd5,
    PH_BASE_NAME  = 4'd6,
    PH_TRAIL      = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_FAIL    = 2'd0,
    ST_OK_EOL  = 2'd1,
    ST_OK_NUL  = 2'd2,
    ST_OK_SEMI = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       first_char;
    logic [1:0] size_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] store_word;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } push_t;

  localparam logic [6:0]  STORE_OPCODE   = 7'b0100011;
  localparam logic [16:0] OFFSET_MAX     = 17'd2047;
  localparam logic [16:0] OFFSET_MIN_MAG = 17'd2048;
  localparam logic [2:0]  MAX_OFF_CHARS  = 3'd5;
  localparam logic [2:0]  MAX_NAME_LEN   = 3'd4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_THREE  = 8'h33;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_EOF    = 8'hFF;

  // Name words hold the first byte in the low byte, unused bytes zero.
  localparam logic [31:0] NAME_ZERO = 32'h6F72657A;
  localparam logic [31:0] NAME_FP   = 32'h00007066;
  localparam logic [4:0]  REG_FP    = 5'd8;

  localparam logic [31:0] ABI_NAME [32] = '{
    32'h6F72657A, 32'h00006172, 32'h00007073, 32'h00007067,
    32'h00007074, 32'h00003074, 32'h00003174, 32'h00003274,
    32'h00003073, 32'h00003173, 32'h00003061, 32'h00003161,
    32'h00003261, 32'h00003361, 32'h00003461, 32'h00003561,
    32'h00003661, 32'h00003761, 32'h00003273, 32'h00003373,
    32'h00003473, 32'h00003573, 32'h00003673, 32'h00003773,
    32'h00003873, 32'h00003973, 32'h00303173, 32'h00313173,
    32'h00003374, 32'h00003474, 32'h00003574, 32'h00003674
  };

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return is_digit(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z));
  endfunction

  // Returns {found, register index}.
  function automatic logic [5:0] name_lookup(logic [31:0] name_w, logic [2:0] len);
    logic       found;
    logic [4:0] reg_idx;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [6:0] two_digit;
    found = 1'b0;
    reg_idx = '0;
    b0 = name_w[7:0];
    b1 = name_w[15:8];
    b2 = name_w[23:16];
    d1 = 4'(b1 - CH_ZERO);
    d2 = 4'(b2 - CH_ZERO);
    two_digit = 7'({d1, 3'b000}) + 7'({d1, 1'b0}) + 7'(d2);
    for (int i = 0; i < 32; i++) begin
      if (name_w == ABI_NAME[i]) begin
        found = 1'b1;
        reg_idx = 5'(i);
      end
    end
    if (name_w == NAME_FP) begin
      found = 1'b1;
      reg_idx = REG_FP;
    end
    if (b0 == CH_LOW_X) begin
      if ((len == 3'd2) && is_digit(b1)) begin
        found = 1'b1;
        reg_idx = 5'(d1);
      end
      if ((len == 3'd3) && (b1 >= CH_ONE) && (b1 <= CH_THREE) && is_digit(b2)
          && (two_digit <= 7'd31)) begin
        found = 1'b1;
        reg_idx = two_digit[4:0];
      end
    end
    return {found, reg_idx};
  endfunction

endpackage

FILE: sv/sote_chan_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel
// One request moves at a rising edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface sote_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/store_operand_text_encoder_core.sv
// ----------------------------------------------------------------------------
// Store operand text encoder
// Parses store operand text such as "x5, -12(sp)" one byte per request and
// returns a status and the S-type store word for each finished or failed line.
//
// in_chan  : requests of text_char, first_char and size_code; first_char
//            starts a new line and drops any line in progress.
// out_chan : results of status and store_word, one per line at most.
// Output   : the result for the byte that ends the line is registered in
//            the output register, or in the skid entry if that is held.
// Rate     : one byte per cycle while in_chan ready is high; each byte is
//            parsed by combinational logic into the line state registers.
// Stall    : an output register and one skid entry hold results; in_chan
//            ready drops only while both are full, i.e. after two results
//            wait on a stalled receiver.
// Reset    : synchronous, active low; the parser returns to idle and both
//            result entries are emptied.
// ----------------------------------------------------------------------------
module store_operand_text_encoder_core (
  input  logic         clk,
  input  logic         rst_n,
  sote_chan_if.sink    in_chan,
  sote_chan_if.source  out_chan
);

  sote_pkg::push_t push;
  logic            buf_ready;

  sote_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .buf_ready (buf_ready),
    .push      (push)
  );

  sote_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .buf_ready (buf_ready),
    .out_chan  (out_chan)
  );

endmodule

FILE: sv/sote_parser.sv
// ----------------------------------------------------------------------------
// Operand text parser
// Holds the line state and steps it by one character per accepted request.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sote_parser (
  input  logic               clk,
  input  logic               rst_n,
  sote_chan_if.sink          in_chan,
  input  logic               buf_ready,
  output sote_pkg::push_t    push
);

  sote_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [31:0] name_r, name_nxt, name_step, name_cur, name_app;
  logic [2:0]  name_len_r, name_len_nxt, name_len_step, name_len_cur, name_len_app;
  logic        neg_r, neg_nxt, neg_step, neg_cur;
  logic [2:0]  off_chars_r, off_chars_nxt, off_chars_step, off_chars_cur;
  logic [16:0] off_val_r, off_val_nxt, off_val_step, off_val_cur;
  logic [4:0]  data_reg_r, data_reg_nxt, data_reg_step, data_reg_cur;
  logic [4:0]  base_reg_r, base_reg_nxt, base_reg_step, base_reg_cur;
  logic [1:0]  size_r, size_cur;
  sote_pkg::phase_t phase_cur;

  logic        accept;
  logic [7:0]  c;
  logic [7:0]  term;
  logic [5:0]  lookup;
  logic [16:0] off_limit;
  logic        fail;
  logic        done;
  sote_pkg::status_t status_code;
  logic [16:0] imm_full;
  logic [11:0] imm;

  assign accept = in_chan.valid && buf_ready;
  assign in_chan.ready = buf_ready;
  assign c = in_chan.payload.text_char;

  // Step one character against the current line view.
  always_comb begin
    if (in_chan.payload.first_char) begin
      phase_cur     = sote_pkg::PH_DATA_NAME;
      name_cur      = '0;
      name_len_cur  = '0;
      neg_cur       = 1'b0;
      off_chars_cur = '0;
      off_val_cur   = '0;
      data_reg_cur  = '0;
      base_reg_cur  = '0;
      size_cur      = in_chan.payload.size_code;
    end else begin
      phase_cur     = phase_r;
      name_cur      = name_r;
      name_len_cur  = name_len_r;
      neg_cur       = neg_r;
      off_chars_cur = off_chars_r;
      off_val_cur   = off_val_r;
      data_reg_cur  = data_reg_r;
      base_reg_cur  = base_reg_r;
      size_cur      = size_r;
    end

    phase_step     = phase_cur;
    name_step      = name_cur;
    name_len_step  = name_len_cur;
    neg_step       = neg_cur;
    off_chars_step = off_chars_cur;
    off_val_step   = off_val_cur;
    data_reg_step  = data_reg_cur;
    base_reg_step  = base_reg_cur;
    fail           = 1'b0;
    done           = 1'b0;
    status_code    = sote_pkg::ST_FAIL;

    lookup    = sote_pkg::name_lookup(name_cur, name_len_cur);
    name_app  = name_cur | (32'(c) << {name_len_cur[1:0], 3'b000});
    name_len_app = name_len_cur + 3'd1;
    term      = (phase_cur == sote_pkg::PH_DATA_NAME) ? sote_pkg::CH_COMMA
                                                      : sote_pkg::CH_RPAREN;
    off_limit = neg_cur ? sote_pkg::OFFSET_MIN_MAG : sote_pkg::OFFSET_MAX;

    case (phase_cur)
      sote_pkg::PH_DATA_NAME, sote_pkg::PH_BASE_NAME: begin
        if (c == term) begin
          if (!lookup[5]) begin
            fail = 1'b1;
          end else begin
            if (phase_cur == sote_pkg::PH_DATA_NAME) begin
              data_reg_step = lookup[4:0];
              phase_step    = sote_pkg::PH_SPACE;
            end else begin
              base_reg_step = lookup[4:0];
              phase_step    = sote_pkg::PH_TRAIL;
            end
            name_step     = '0;
            name_len_step = '0;
          end
        end else if (!sote_pkg::is_name_char(c) || (name_len_cur >= sote_pkg::MAX_NAME_LEN)) begin
          fail = 1'b1;
        end else begin
          name_step     = name_app;
          name_len_step = name_len_app;
          if ((name_len_app == sote_pkg::MAX_NAME_LEN) && (name_app != sote_pkg::NAME_ZERO)) begin
            fail = 1'b1;
          end
        end
      end
      sote_pkg::PH_SPACE: begin
        if (c == sote_pkg::CH_SPACE) begin
          phase_step = sote_pkg::PH_OFF_START;
        end else begin
          fail = 1'b1;
        end
      end
      sote_pkg::PH_OFF_START: begin
        if ((c == sote_pkg::CH_PLUS) || (c == sote_pkg::CH_MINUS)) begin
          neg_step       = (c == sote_pkg::CH_MINUS);
          off_chars_step = 3'd1;
          phase_step     = sote_pkg::PH_OFF_SIGNED;
        end else if (sote_pkg::is_digit(c)) begin
          off_val_step   = 17'(c - sote_pkg::CH_ZERO);
          off_chars_step = 3'd1;
          phase_step     = sote_pkg::PH_OFF_DIGITS;
        end else begin
          fail = 1'b1;
        end
      end
      sote_pkg::PH_OFF_SIGNED: begin
        if (sote_pkg::is_digit(c)) begin
          off_val_step   = 17'(c - sote_pkg::CH_ZERO);
          off_chars_step = 3'd2;
          phase_step     = sote_pkg::PH_OFF_DIGITS;
        end else begin
          fail = 1'b1;
        end
      end
      sote_pkg::PH_OFF_DIGITS: begin
        if (c == sote_pkg::CH_LPAREN) begin
          if (off_val_cur > off_limit) begin
            fail = 1'b1;
          end else begin
            phase_step = sote_pkg::PH_BASE_NAME;
          end
        end else if (sote_pkg::is_digit(c) && (off_chars_cur < sote_pkg::MAX_OFF_CHARS)) begin
          off_val_step   = (off_val_cur << 3) + (off_val_cur << 1)
                         + 17'(c - sote_pkg::CH_ZERO);
          off_chars_step = off_chars_cur + 3'd1;
        end else begin
          fail = 1'b1;
        end
      end
      sote_pkg::PH_TRAIL: begin
        if (c == sote_pkg::CH_SPACE) begin
          done = 1'b0;
        end else if ((c == sote_pkg::CH_LF) || (c == sote_pkg::CH_EOF)) begin
          done = 1'b1;
          status_code = sote_pkg::ST_OK_EOL;
        end else if (c == sote_pkg::CH_NUL) begin
          done = 1'b1;
          status_code = sote_pkg::ST_OK_NUL;
        end else if (c == sote_pkg::CH_SEMI) begin
          done = 1'b1;
          status_code = sote_pkg::ST_OK_SEMI;
        end else begin
          fail = 1'b1;
        end
      end
      default: begin
        phase_step = sote_pkg::PH_IDLE;
      end
    endcase
  end

  // Next state: drop the line after any result.
  always_comb begin
    if (fail || done) begin
      phase_nxt     = sote_pkg::PH_IDLE;
      name_nxt      = '0;
      name_len_nxt  = '0;
      neg_nxt       = 1'b0;
      off_chars_nxt = '0;
      off_val_nxt   = '0;
      data_reg_nxt  = '0;
      base_reg_nxt  = '0;
    end else begin
      phase_nxt     = phase_step;
      name_nxt      = name_step;
      name_len_nxt  = name_len_step;
      neg_nxt       = neg_step;
      off_chars_nxt = off_chars_step;
      off_val_nxt   = off_val_step;
      data_reg_nxt  = data_reg_step;
      base_reg_nxt  = base_reg_step;
    end
  end

  // Outputs: status and encoded word.
  always_comb begin
    imm_full = neg_cur ? (17'd0 - off_val_cur) : off_val_cur;
    imm      = imm_full[11:0];
    push.valid = accept && (fail || done);
    if (done) begin
      push.item.status     = status_code;
      push.item.store_word = {imm[11:5], data_reg_cur, base_reg_cur, 1'b0, size_cur,
                              imm[4:0], sote_pkg::STORE_OPCODE};
    end else begin
      push.item.status     = sote_pkg::ST_FAIL;
      push.item.store_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sote_pkg::PH_IDLE;
      name_r      <= '0;
      name_len_r  <= '0;
      neg_r       <= 1'b0;
      off_chars_r <= '0;
      off_val_r   <= '0;
      data_reg_r  <= '0;
      base_reg_r  <= '0;
      size_r      <= '0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      name_r      <= name_nxt;
      name_len_r  <= name_len_nxt;
      neg_r       <= neg_nxt;
      off_chars_r <= off_chars_nxt;
      off_val_r   <= off_val_nxt;
      data_reg_r  <= data_reg_nxt;
      base_reg_r  <= base_reg_nxt;
      size_r      <= size_cur;
    end
  end

  `ASSERT_CLK(a_fail_word_zero, push.valid && (push.item.status == sote_pkg::ST_FAIL) |-> push.item.store_word == '0)
  `ASSERT_CLK(a_idle_after_result, push.valid |=> phase_r == sote_pkg::PH_IDLE)

endmodule

FILE: sv/sote_out_buf.sv
// ----------------------------------------------------------------------------
// Result buffer
// Output register plus one skid entry; input side stalls only when both hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sote_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  sote_pkg::push_t    push,
  output logic               buf_ready,
  sote_chan_if.source        out_chan
);

  logic                 out_valid_r;
  sote_pkg::out_item_t  out_item_r;
  logic                 skid_valid_r;
  sote_pkg::out_item_t  skid_item_r;
  logic                 take;

  assign take          = out_valid_r && out_chan.ready;
  assign buf_ready     = !skid_valid_r;
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= push.valid;
      end else begin
        out_valid_r  <= push.valid;
        skid_valid_r <= 1'b0;
      end
    end else if (push.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || take) begin
      if (skid_valid_r) begin
        out_item_r  <= skid_item_r;
        skid_item_r <= push.item;
      end else begin
        out_item_r  <= push.item;
      end
    end else if (push.valid) begin
      skid_item_r <= push.item;
    end
  end

  `ASSERT_CLK(a_skid_needs_out, skid_valid_r |-> out_valid_r)
  `ASSERT_NEVER(a_no_push_when_full, push.valid && skid_valid_r)
  `ASSERT_CLK(a_skid_drains, take && skid_valid_r |=> out_valid_r)

endmodule

FILE: sim/sote_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store operand text encoder bench package
// Line parser mirror and result scoreboard for the store operand encoder,
// plus the register name text used to build operand lines.
// ----------------------------------------------------------------------------
package sote_tb_pkg;
  import sote_pkg::*;

  typedef logic [7:0] text_q_t[$];

  function automatic string abi_text(int idx);
    case (idx)
      0: return "zero";   1: return "ra";    2: return "sp";    3: return "gp";
      4: return "tp";     5: return "t0";    6: return "t1";    7: return "t2";
      8: return "s0";     9: return "s1";   10: return "a0";   11: return "a1";
      12: return "a2";   13: return "a3";   14: return "a4";   15: return "a5";
      16: return "a6";   17: return "a7";   18: return "s2";   19: return "s3";
      20: return "s4";   21: return "s5";   22: return "s6";   23: return "s7";
      24: return "s8";   25: return "s9";   26: return "s10";  27: return "s11";
      28: return "t3";   29: return "t4";   30: return "t5";
      default: return "t6";
    endcase
  endfunction

  class store_word_scoreboard;
    out_item_t   pending_words[$];
    int          mismatches;
    int          results_checked;
    phase_t      phase;
    logic [31:0] name_buf;
    logic [2:0]  name_len;
    logic        neg;
    logic [2:0]  off_chars;
    logic [16:0] off_mag;
    logic [4:0]  rs2;
    logic [4:0]  rs1;
    logic [1:0]  size;

    function new();
      clear_line();
      size = '0;
      mismatches = 0;
      results_checked = 0;
    endfunction

    function void clear_line();
      phase = PH_IDLE;
      name_buf = '0;
      name_len = '0;
      neg = 1'b0;
      off_chars = '0;
      off_mag = '0;
      rs2 = '0;
      rs1 = '0;
    endfunction

    static function bit is_dec(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function bit append_name_byte(logic [7:0] c);
      if (!(is_dec(c) || ((c >= CH_LOW_A) && (c <= CH_LOW_Z)))) return 1'b0;
      if (name_len >= MAX_NAME_LEN) return 1'b0;
      name_buf[8*name_len +: 8] = c;
      name_len++;
      return !((name_len == 3'd4) && (name_buf != NAME_ZERO));
    endfunction

    function bit decode_reg_name(output logic [4:0] idx);
      string nm;
      bit    same;
      int    v;
      idx = '0;
      if (name_len == 0) return 1'b0;
      for (int i = 0; i < 32; i++) begin
        nm = abi_text(i);
        if (nm.len() != name_len) continue;
        same = 1'b1;
        for (int j = 0; j < nm.len(); j++)
          if (nm.getc(j) != name_buf[8*j +: 8]) same = 1'b0;
        if (same) begin
          idx = 5'(i);
          return 1'b1;
        end
      end
      if ((name_len == 3'd2) && (name_buf[7:0] == "f") && (name_buf[15:8] == "p")) begin
        idx = 5'd8;
        return 1'b1;
      end
      if (name_buf[7:0] == CH_LOW_X) begin
        if ((name_len == 3'd2) && is_dec(name_buf[15:8])) begin
          idx = 5'(name_buf[15:8] - CH_ZERO);
          return 1'b1;
        end
        if ((name_len == 3'd3) && (name_buf[15:8] >= CH_ONE) && (name_buf[15:8] <= CH_THREE)
            && is_dec(name_buf[23:16])) begin
          v = (name_buf[15:8] - CH_ZERO) * 10 + (name_buf[23:16] - CH_ZERO);
          if (v <= 31) begin
            idx = 5'(v);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function void take_text_char(in_item_t it);
      logic [7:0]  c;
      logic [4:0]  idx;
      logic [11:0] imm;
      status_t     st;
      out_item_t   res;
      bit          fail;
      bit          done;
      c = it.text_char;
      fail = 1'b0;
      done = 1'b0;
      st = ST_FAIL;
      if (it.first_char) begin
        clear_line();
        size = it.size_code;
        phase = PH_DATA_NAME;
      end
      case (phase)
        PH_DATA_NAME, PH_BASE_NAME: begin
          if (c == ((phase == PH_DATA_NAME) ? CH_COMMA : CH_RPAREN)) begin
            if (!decode_reg_name(idx)) begin
              fail = 1'b1;
            end else begin
              if (phase == PH_DATA_NAME) begin
                rs2 = idx;
                phase = PH_SPACE;
              end else begin
                rs1 = idx;
                phase = PH_TRAIL;
              end
              name_buf = '0;
              name_len = '0;
            end
          end else if (!append_name_byte(c)) begin
            fail = 1'b1;
          end
        end
        PH_SPACE: begin
          if (c == CH_SPACE) phase = PH_OFF_START;
          else fail = 1'b1;
        end
        PH_OFF_START: begin
          if ((c == CH_PLUS) || (c == CH_MINUS)) begin
            neg = (c == CH_MINUS);
            off_chars = 3'd1;
            phase = PH_OFF_SIGNED;
          end else if (is_dec(c)) begin
            off_mag = 17'(c - CH_ZERO);
            off_chars = 3'd1;
            phase = PH_OFF_DIGITS;
          end else begin
            fail = 1'b1;
          end
        end
        PH_OFF_SIGNED: begin
          if (is_dec(c)) begin
            off_mag = 17'(c - CH_ZERO);
            off_chars = 3'd2;
            phase = PH_OFF_DIGITS;
          end else begin
            fail = 1'b1;
          end
        end
        PH_OFF_DIGITS: begin
          if (c == CH_LPAREN) begin
            if (off_mag > (neg ? OFFSET_MIN_MAG : OFFSET_MAX)) fail = 1'b1;
            else phase = PH_BASE_NAME;
          end else if (is_dec(c) && (off_chars < MAX_OFF_CHARS)) begin
            off_mag = 17'(off_mag * 10 + (c - CH_ZERO));
            off_chars++;
          end else begin
            fail = 1'b1;
          end
        end
        PH_TRAIL: begin
          if (c != CH_SPACE) begin
            done = 1'b1;
            if ((c == CH_LF) || (c == CH_EOF)) st = ST_OK_EOL;
            else if (c == CH_NUL) st = ST_OK_NUL;
            else if (c == CH_SEMI) st = ST_OK_SEMI;
            else begin
              fail = 1'b1;
              done = 1'b0;
            end
          end
        end
        default: begin
          phase = PH_IDLE;
          return;
        end
      endcase
      if (fail) begin
        clear_line();
        res.status = ST_FAIL;
        res.store_word = '0;
        pending_words.push_back(res);
      end else if (done) begin
        imm = neg ? 12'(-off_mag) : 12'(off_mag);
        res.status = st;
        res.store_word = {imm[11:5], rs2, rs1, 1'b0, size, imm[4:0], STORE_OPCODE};
        pending_words.push_back(res);
        clear_line();
      end
    endfunction

    function void check_store_result(out_item_t got);
      out_item_t want;
      results_checked++;
      if (pending_words.size() == 0) begin
        $error("store result with nothing pending: status %0d, store_word %h",
               got.status, got.store_word);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.store_word !== want.store_word) begin
        $error("store_word: expected %h, actual %h", want.store_word, got.store_word);
        mismatches++;
      end
    endfunction
  endclass

endpackage

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store operand text encoder bench
// Streams store operand lines, well formed and damaged, one byte per request
// with random gaps and receiver stalls, and checks every status and S-type
// word against a line parser mirror kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  import sote_pkg::*;
  import sote_tb_pkg::*;

  localparam int TEXT_BYTES   = 1150;
  localparam int QUIET_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_PERCENT = 16;
  localparam int NO_TAIL      = -1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   src_pause_on = 1'b1;
  bit   sink_pause_on = 1'b1;
  bit   hold_request = 1'b0;
  int   quiet_cycles = 0;
  int   text_bytes = 0;
  int   lines_sent = 0;
  int   noise_bytes = 0;
  store_word_scoreboard sb;

  sote_chan_if #(.payload_t(in_item_t))  in_chan ();
  sote_chan_if #(.payload_t(out_item_t)) out_chan ();

  store_operand_text_encoder_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  function automatic text_q_t text_of(string s);
    text_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s.getc(i));
    return q;
  endfunction

  function automatic string reg_text();
    case ($urandom_range(11))
      0, 1, 2, 3, 4: return abi_text($urandom_range(31));
      5, 6, 7: return $sformatf("x%0d", $urandom_range(31));
      8: return "fp";
      9: return $sformatf("x%0d", $urandom_range(99, 32));
      10: begin
        case ($urandom_range(7))
          0: return "x03";
          1: return "fq";
          2: return "s12";
          3: return "zeros";
          4: return "zerx";
          5: return "";
          6: return "X1";
          default: return "a8";
        endcase
      end
      default: return "zero";
    endcase
  endfunction

  function automatic string offset_text();
    int    v;
    string sgn;
    string digits;
    case ($urandom_range(9))
      0: v = -2048;
      1: v = 2047;
      2: v = 2048 + $urandom_range(20);
      3: v = -2049 - $urandom_range(20);
      4: v = $urandom_range(9);
      default: v = $urandom_range(4095) - 2048;
    endcase
    digits = $sformatf("%0d", (v < 0) ? -v : v);
    if (v < 0) sgn = "-";
    else if ($urandom_range(3) == 0) sgn = "+";
    else sgn = "";
    if ((v == 0) && ($urandom_range(3) == 0)) sgn = "-";
    if ($urandom_range(7) == 0) digits = {"0", digits};
    if ($urandom_range(39) == 0) digits = "";
    if ($urandom_range(39) == 0) digits = "99999";
    return {sgn, digits};
  endfunction

  function automatic logic [7:0] end_char();
    case ($urandom_range(9))
      0, 1, 2: return CH_LF;
      3: return CH_EOF;
      4, 5: return CH_NUL;
      6, 7: return CH_SEMI;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic text_q_t random_line();
    string   s;
    text_q_t q;
    s = {reg_text(), ","};
    case ($urandom_range(19))
      0: ;
      1: s = {s, "  "};
      2: s = {s, "\t"};
      default: s = {s, " "};
    endcase
    s = {s, offset_text(), "(", reg_text(), ")"};
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) s = {s, " "};
    q = text_of(s);
    q.push_back(end_char());
    return q;
  endfunction

  task automatic send_char(in_item_t it);
    if (src_pause_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.payload <= it;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_line(text_q_t line, logic [1:0] size);
    in_item_t it;
    for (int i = 0; i < line.size(); i++) begin
      it.text_char  = line[i];
      it.first_char = (i == 0);
      it.size_code  = (i == 0) ? size : 2'($urandom_range(3));
      send_char(it);
      text_bytes++;
    end
    lines_sent++;
  endtask

  task automatic send_text(string body, int tail, logic [1:0] size);
    text_q_t line;
    line = text_of(body);
    if (tail >= 0) line.push_back(8'(tail));
    send_line(line, size);
  endtask

  task automatic send_noise();
    in_item_t it;
    it.text_char  = 8'($urandom_range(255));
    it.first_char = 1'b0;
    it.size_code  = 2'($urandom_range(3));
    send_char(it);
    noise_bytes++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_chan.ready <= 1'b0;
        hold--;
      end else begin
        out_chan.ready <= !(sink_pause_on && ($urandom_range(99) < IDLE_PERCENT));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) sb.check_store_result(out_chan.payload);
      if (in_chan.valid && in_chan.ready) sb.take_text_char(in_chan.payload);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    text_q_t line;
    int      r;
    int      k;
    bit      hold_done;
    hold_done = 1'b0;
    sb = new();
    in_chan.valid   <= 1'b0;
    in_chan.payload <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_noise();
    send_text("zero, -2048(x31)", CH_SEMI, 2'd3);
    send_text("t6, 2047(fp)  ", CH_EOF, 2'd0);
    send_text("x1", NO_TAIL, 2'd1);
    send_text("s11, +0(a7)", CH_NUL, 2'd2);
    send_text("a0, 5(sp)", CH_LF, 2'd1);
    send_text("ra, 2048(", NO_TAIL, 2'd2);
    send_text("gp, -2049(", NO_TAIL, 2'd3);
    send_text("x9, -(", NO_TAIL, 2'd0);
    send_text("x9, 000001", NO_TAIL, 2'd1);
    send_text("zerx", NO_TAIL, 2'd2);
    send_text("zeros", NO_TAIL, 2'd3);
    send_text("x", CH_NUL, 2'd0);
    send_text("abc,", NO_TAIL, 2'd1);
    send_text("x5,  ", NO_TAIL, 2'd2);
    send_text("x3, 7(x4) q", NO_TAIL, 2'd3);
    send_noise();

    while (text_bytes < TEXT_BYTES) begin
      src_pause_on  = !((text_bytes >= 450) && (text_bytes < 800));
      sink_pause_on = src_pause_on;
      if (!hold_done && (text_bytes >= 200)) begin
        hold_request = 1'b1;
        hold_done = 1'b1;
      end
      line = random_line();
      r = $urandom_range(99);
      if (r < 15) begin
        line[$urandom_range(line.size() - 1)] = 8'($urandom_range(255));
      end else if (r < 25) begin
        k = $urandom_range(line.size() - 1, 1);
        while (line.size() > k) void'(line.pop_back());
      end
      send_line(line, 2'($urandom_range(3)));
      if (r >= 95) repeat ($urandom_range(1, 3)) send_noise();
    end
    in_chan.valid <= 1'b0;

    @(posedge clk);
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("tb_top: %0d text bytes over %0d lines, %0d stray bytes between lines",
             text_bytes, lines_sent, noise_bytes);
    $display("tb_top: %0d store results compared, %0d mismatches",
             sb.results_checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
